>>> rtl/mbrtu_pkg.sv
`default_nettype none
// ============================================================================
// mbrtu_pkg
// Shared types, microprogram and CRC table for the Modbus RTU write framer.
// ============================================================================
package mbrtu_pkg;

    localparam int STEP_W = 4;

    localparam logic [7:0]  FUNC_WRITE_SINGLE   = 8'h06;
    localparam logic [7:0]  FUNC_WRITE_MULTIPLE = 8'h10;
    localparam logic [7:0]  MULTI_COUNT_HI      = 8'h00;
    localparam logic [7:0]  MULTI_COUNT_LO      = 8'h01;
    localparam logic [7:0]  MULTI_BYTE_COUNT    = 8'h02;
    localparam logic [15:0] CRC_INIT            = 16'hFFFF;
    localparam logic [15:0] CRC_POLY_REFLECTED  = 16'hA001;

    typedef struct packed {
        logic [7:0]  slave_address;
        logic [15:0] register_address;
        logic [15:0] register_value;
        logic        opcode;
        logic [7:0]  channel;
    } request_t;

    typedef struct packed {
        logic [7:0] frame_byte;
        logic [7:0] channel_tag;
        logic       last_byte;
    } result_t;

    typedef enum logic [3:0] {
        SRC_ADDR,
        SRC_FUNC,
        SRC_REG_HI,
        SRC_REG_LO,
        SRC_CNT_HI,
        SRC_CNT_LO,
        SRC_BCNT,
        SRC_VAL_HI,
        SRC_VAL_LO,
        SRC_CRC_LO,
        SRC_CRC_HI
    } byte_src_t;

    typedef enum logic {
        JMP_NONE,
        JMP_IF_SINGLE
    } jump_cond_t;

    typedef struct packed {
        byte_src_t         src;
        logic              crc_upd;
        logic              last;
        jump_cond_t        jump;
        logic [STEP_W-1:0] target;
        logic              fin;
    } ctrl_word_t;

    typedef struct packed {
        logic      load;
        logic      exec;
        byte_src_t src;
        logic      crc_upd;
        logic      last;
    } dp_ctl_t;

    localparam logic [STEP_W-1:0] STEP_VAL_HI = 4'd7;

    function automatic ctrl_word_t ucode(input logic [STEP_W-1:0] step);
        ctrl_word_t cw;
        cw = '{src: SRC_CRC_HI, crc_upd: 1'b0, last: 1'b1, jump: JMP_NONE,
               target: '0, fin: 1'b1};
        unique case (step)
            4'd0:  cw = '{SRC_ADDR,   1'b1, 1'b0, JMP_NONE,      '0,          1'b0};
            4'd1:  cw = '{SRC_FUNC,   1'b1, 1'b0, JMP_NONE,      '0,          1'b0};
            4'd2:  cw = '{SRC_REG_HI, 1'b1, 1'b0, JMP_NONE,      '0,          1'b0};
            4'd3:  cw = '{SRC_REG_LO, 1'b1, 1'b0, JMP_IF_SINGLE, STEP_VAL_HI, 1'b0};
            4'd4:  cw = '{SRC_CNT_HI, 1'b1, 1'b0, JMP_NONE,      '0,          1'b0};
            4'd5:  cw = '{SRC_CNT_LO, 1'b1, 1'b0, JMP_NONE,      '0,          1'b0};
            4'd6:  cw = '{SRC_BCNT,   1'b1, 1'b0, JMP_NONE,      '0,          1'b0};
            4'd7:  cw = '{SRC_VAL_HI, 1'b1, 1'b0, JMP_NONE,      '0,          1'b0};
            4'd8:  cw = '{SRC_VAL_LO, 1'b1, 1'b0, JMP_NONE,      '0,          1'b0};
            4'd9:  cw = '{SRC_CRC_LO, 1'b0, 1'b0, JMP_NONE,      '0,          1'b0};
            4'd10: cw = '{SRC_CRC_HI, 1'b0, 1'b1, JMP_NONE,      '0,          1'b1};
            default: cw = '{SRC_CRC_HI, 1'b0, 1'b1, JMP_NONE,    '0,          1'b1};
        endcase
        return cw;
    endfunction

    function automatic logic [15:0] crc_entry(input logic [7:0] idx);
        logic [15:0] c;
        c = {8'h00, idx};
        for (int b = 0; b < 8; b++) begin
            if (c[0])
            begin
                c = (c >> 1) ^ CRC_POLY_REFLECTED;
            end
            else
            begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage
`default_nettype wire

>>> rtl/mbrtu_seq.sv
`default_nettype none
// ============================================================================
// mbrtu_seq
// Microcode sequencer: step counter, control store and conditional jump.
// ============================================================================
module mbrtu_seq
    import mbrtu_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    start,
    input  wire logic    is_multi,
    output dp_ctl_t      ctl,
    output logic         busy
);

    logic [STEP_W-1:0] step_reg, step_next;
    logic              run_reg, run_next;
    ctrl_word_t        cw;
    logic              accept;

    assign accept = start && !run_reg;
    assign cw     = ucode(step_reg);
    assign busy   = run_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            run_reg  <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            run_reg  <= run_next;
        end
    end

    always_comb
    begin
        step_next = step_reg;
        run_next  = run_reg;
        if (accept)
        begin
            step_next = '0;
            run_next  = 1'b1;
        end
        else if (run_reg)
        begin
            if (cw.fin)
            begin
                run_next = 1'b0;
            end
            else if (cw.jump == JMP_IF_SINGLE && !is_multi)
            begin
                step_next = cw.target;
            end
            else
            begin
                step_next = step_reg + 1'b1;
            end
        end
    end

    assign ctl.load    = accept;
    assign ctl.exec    = run_reg;
    assign ctl.src     = cw.src;
    assign ctl.crc_upd = cw.crc_upd;
    assign ctl.last    = cw.last;

endmodule
`default_nettype wire

>>> rtl/mbrtu_dp.sv
`default_nettype none
// ============================================================================
// mbrtu_dp
// Datapath: request register, byte selector, CRC-16 register, result register.
// ============================================================================
module mbrtu_dp
    import mbrtu_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire request_t request,
    input  wire dp_ctl_t  ctl,
    output logic          is_multi,
    output result_t       result,
    output logic          strobe
);

    request_t    req_reg;
    logic [15:0] crc_reg, crc_next;
    result_t     result_reg;
    logic        strobe_reg;
    logic [7:0]  sel_byte;

    assign is_multi = req_reg.opcode;

    always_comb
    begin
        unique case (ctl.src)
            SRC_ADDR:   sel_byte = req_reg.slave_address;
            SRC_FUNC:   sel_byte = req_reg.opcode ? FUNC_WRITE_MULTIPLE : FUNC_WRITE_SINGLE;
            SRC_REG_HI: sel_byte = req_reg.register_address[15:8];
            SRC_REG_LO: sel_byte = req_reg.register_address[7:0];
            SRC_CNT_HI: sel_byte = MULTI_COUNT_HI;
            SRC_CNT_LO: sel_byte = MULTI_COUNT_LO;
            SRC_BCNT:   sel_byte = MULTI_BYTE_COUNT;
            SRC_VAL_HI: sel_byte = req_reg.register_value[15:8];
            SRC_VAL_LO: sel_byte = req_reg.register_value[7:0];
            SRC_CRC_LO: sel_byte = crc_reg[7:0];
            SRC_CRC_HI: sel_byte = crc_reg[15:8];
            default:    sel_byte = crc_reg[15:8];
        endcase
    end

    always_comb
    begin
        crc_next = crc_reg;
        if (ctl.load)
        begin
            crc_next = CRC_INIT;
        end
        else if (ctl.exec && ctl.crc_upd)
        begin
            crc_next = {8'h00, crc_reg[15:8]} ^ crc_entry(crc_reg[7:0] ^ sel_byte);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            req_reg <= request;
        end
        crc_reg <= crc_next;
        if (ctl.exec)
        begin
            result_reg.frame_byte  <= sel_byte;
            result_reg.channel_tag <= req_reg.channel;
            result_reg.last_byte   <= ctl.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strobe_reg <= 1'b0;
        end
        else
        begin
            strobe_reg <= ctl.exec;
        end
    end

    assign result = result_reg;
    assign strobe = strobe_reg;

endmodule
`default_nettype wire

>>> rtl/modbus_rtu_write_request_framer_core.sv
`default_nettype none
// ============================================================================
// modbus_rtu_write_request_framer_core
// Builds a Modbus RTU write-register request frame with CRC-16, byte by byte.
// ============================================================================
//  Channel   Signals                 Handshake
//  request   request, start, busy    word taken when start && !busy
//  result    result, strobe          word valid for the one cycle strobe is high
//
//  A request is loaded while idle, then one microcode step runs per cycle:
//  function 0x06 skips the count and byte-count steps; 0x10 runs them all.
//  A new request is taken only after the last step of the current frame.
//  Each byte appears the cycle after its step; a frame's bytes are contiguous.
//  Reset clears the sequencer and the strobe. The receiver cannot stall.
// ============================================================================
module modbus_rtu_write_request_framer_core
    import mbrtu_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    input  wire request_t request,
    output logic          busy,
    output result_t       result,
    output logic          strobe
);

    dp_ctl_t ctl;
    logic    is_multi;

    mbrtu_seq u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (start),
        .is_multi (is_multi),
        .ctl      (ctl),
        .busy     (busy)
    );

    mbrtu_dp u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (request),
        .ctl      (ctl),
        .is_multi (is_multi),
        .result   (result),
        .strobe   (strobe)
    );

    a_strobe_follows_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> $past(busy))
        else $error("result word without a running step");

    a_frame_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !result.last_byte |=> strobe)
        else $error("gap inside a frame");

    a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && result.last_byte |=> !strobe)
        else $error("word right after the last byte");

    a_start_runs: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("request taken but sequencer idle");

endmodule
`default_nettype wire
